// ===== src/iqe_pkg.sv =====
// iqe_pkg: shared types, constants and helpers of the infix expression evaluator
// used by the result channel interface, the serial multiply/divide unit and the top level
// no dependencies

package iqe_pkg;

  // fixed-point format
  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = 32;
  localparam int VAL_W     = 48;
  localparam int SAT_W     = ((INT_BITS + FRAC_BITS) < VAL_W) ? (INT_BITS + FRAC_BITS) : VAL_W;
  localparam int NUM_W     = 31;
  localparam int STAT_W    = 2;

  // saturation limits as magnitudes of SAT_W bits
  localparam logic [SAT_W-1:0] SAT_MAX     = {1'b0, {(SAT_W-1){1'b1}}};
  localparam logic [SAT_W-1:0] SAT_MIN_MAG = {1'b1, {(SAT_W-1){1'b0}}};

  // largest decimal literal
  localparam logic [NUM_W-1:0] NUM_MAX = ((SAT_W - 1 - FRAC_BITS) >= NUM_W) ?
    {NUM_W{1'b1}} : NUM_W'((64'd1 << (SAT_W - 1 - FRAC_BITS)) - 64'd1);

  // character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SYNTAX   = 2'd1,
    ST_DIVZERO  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MP_NONE = 2'd0,
    MP_MUL  = 2'd1,
    MP_DIV  = 2'd2
  } mul_pend_e;

  typedef enum logic [2:0] {
    OP_PLUS,
    OP_MINUS,
    OP_MUL,
    OP_DIV,
    OP_END
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE,
    S_CALC,
    S_OPER,
    S_FINISH
  } state_e;

  typedef enum logic {
    SU_MUL,
    SU_DIV
  } su_op_e;

  // control between the top level and the serial unit
  typedef struct packed {
    logic   start;
    su_op_e op;
  } su_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } su_rsp_t;

  // magnitude of a two's complement value
  function automatic logic [VAL_W-1:0] mag_of(logic signed [VAL_W-1:0] v);
    logic [VAL_W-1:0] m;
    m = v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
    return m;
  endfunction

endpackage

// ===== src/iqe_char_if.sv =====
// iqe_char_if: input channel carrying one expression character per item
// depends on nothing

interface iqe_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ===== src/iqe_res_if.sv =====
// iqe_res_if: output channel carrying the value and status of one expression
// depends on iqe_pkg

interface iqe_res_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [iqe_pkg::VAL_W-1:0]     value;
  logic        [iqe_pkg::STAT_W-1:0]    status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== src/infix_expression_evaluator_unit.sv =====
// infix_expression_evaluator_unit: top level, character parser, accumulators and output item
// depends on iqe_pkg, iqe_char_if, iqe_res_if and iqe_serial_unit

// Evaluates an ASCII expression of non-negative decimal numbers joined by + - * /
// (no parentheses, * and / before + and -, left to right), one character per input
// item; the item with last set yields one result item with a signed Q31.16 value and
// a status (ok, syntax error, divide by zero, overflow with saturation). A digit, a
// space or an operator after a syntax or divide-by-zero error is only consumed. An
// operator that finishes a multiply or divide waits for the bit-serial multiply/divide
// unit, which produces one bit of the 48 x 48 product or of the 64-bit quotient per
// cycle and then saturates the result. After the final character the result is
// loaded into the output register as soon as any earlier result has been taken,
// which frees the input side while the result waits to be taken.

module infix_expression_evaluator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  iqe_char_if.sink   in_i,
  iqe_res_if.source  res_o
);

  localparam int VW = iqe_pkg::VAL_W;
  localparam int NW = iqe_pkg::NUM_W;
  localparam logic signed [VW:0] POS_LIM =
    $signed({{(VW + 1 - iqe_pkg::SAT_W){1'b0}}, iqe_pkg::SAT_MAX});
  localparam logic signed [VW:0] NEG_LIM = -POS_LIM - (VW + 1)'(1);

  iqe_pkg::state_e      state_q, state_d;
  logic signed [VW-1:0] sum_q, sum_d;
  logic signed [VW-1:0] term_q, term_d;
  logic                 sign_q, sign_d;
  iqe_pkg::mul_pend_e   mul_q, mul_d;
  logic [NW-1:0]        num_q, num_d;
  logic                 have_q, have_d;
  iqe_pkg::status_e     err_q, err_d;
  iqe_pkg::op_e         op_q, op_d;
  logic                 out_valid_q, out_valid_d;
  logic signed [VW-1:0] out_value_q, out_value_d;
  iqe_pkg::status_e     out_status_q, out_status_d;

  logic                 in_acc;
  logic                 hard_err;
  logic                 is_digit, is_space, is_op;
  iqe_pkg::op_e         char_op;
  logic [3:0]           dig;
  logic [NW+3:0]        num_ext;
  logic                 num_ovf;
  logic signed [VW-1:0] num_val;
  logic signed [VW:0]   tot;
  logic                 out_free;
  iqe_pkg::su_req_t     su_req;
  iqe_pkg::su_rsp_t     su_rsp;
  logic signed [VW-1:0] su_res;

  // serial multiply/divide
  iqe_serial_unit u_serial (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (su_req),
    .a_i    (term_q),
    .b_i    (num_val),
    .rsp_o  (su_rsp),
    .res_o  (su_res)
  );

  // character classification
  always_comb begin
    is_digit = (in_i.char_code >= iqe_pkg::CH_ZERO) && (in_i.char_code <= iqe_pkg::CH_NINE);
    is_space = (in_i.char_code == iqe_pkg::CH_SPACE);
    is_op    = 1'b1;
    char_op  = iqe_pkg::OP_PLUS;
    case (in_i.char_code)
      iqe_pkg::CH_PLUS:  char_op = iqe_pkg::OP_PLUS;
      iqe_pkg::CH_MINUS: char_op = iqe_pkg::OP_MINUS;
      iqe_pkg::CH_MUL:   char_op = iqe_pkg::OP_MUL;
      iqe_pkg::CH_DIV:   char_op = iqe_pkg::OP_DIV;
      default:           is_op   = 1'b0;
    endcase
    dig = 4'(in_i.char_code - iqe_pkg::CH_ZERO);
  end

  // arithmetic on the number and the sum
  always_comb begin
    num_ext = ((NW + 4)'(num_q) << 3) + ((NW + 4)'(num_q) << 1) + (NW + 4)'(dig);
    num_ovf = num_ext > (NW + 4)'(iqe_pkg::NUM_MAX);
    num_val = VW'(num_q) << iqe_pkg::FRAC_BITS;
    tot     = sign_q ? ({sum_q[VW-1], sum_q} - {term_q[VW-1], term_q})
                     : ({sum_q[VW-1], sum_q} + {term_q[VW-1], term_q});
  end

  assign hard_err = (err_q == iqe_pkg::ST_SYNTAX) || (err_q == iqe_pkg::ST_DIVZERO);
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || res_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      iqe_pkg::S_IDLE: begin
        if (in_acc) begin
          if (hard_err) begin
            if (in_i.last) state_d = iqe_pkg::S_FINISH;
          end else if (is_digit || is_space) begin
            if (in_i.last) state_d = (is_digit || have_q) ? iqe_pkg::S_CLOSE : iqe_pkg::S_FINISH;
          end else if (is_op && have_q && !in_i.last) begin
            state_d = iqe_pkg::S_CLOSE;
          end else if (in_i.last) begin
            state_d = iqe_pkg::S_FINISH;
          end
        end
      end
      iqe_pkg::S_CLOSE: begin
        if (mul_q == iqe_pkg::MP_MUL) begin
          state_d = iqe_pkg::S_CALC;
        end else if (mul_q == iqe_pkg::MP_DIV) begin
          if (num_q == '0) begin
            state_d = (op_q == iqe_pkg::OP_END) ? iqe_pkg::S_FINISH : iqe_pkg::S_IDLE;
          end else begin
            state_d = iqe_pkg::S_CALC;
          end
        end else begin
          state_d = iqe_pkg::S_OPER;
        end
      end
      iqe_pkg::S_CALC: begin
        if (su_rsp.done) state_d = iqe_pkg::S_OPER;
      end
      iqe_pkg::S_OPER: begin
        state_d = (op_q == iqe_pkg::OP_END) ? iqe_pkg::S_FINISH : iqe_pkg::S_IDLE;
      end
      iqe_pkg::S_FINISH: begin
        if (out_free) state_d = iqe_pkg::S_IDLE;
      end
      default: state_d = iqe_pkg::S_IDLE;
    endcase
  end

  // handshake and unit control
  always_comb begin
    in_i.ready   = (state_q == iqe_pkg::S_IDLE);
    su_req.start = (state_q == iqe_pkg::S_CLOSE) &&
                   ((mul_q == iqe_pkg::MP_MUL) || ((mul_q == iqe_pkg::MP_DIV) && (num_q != '0)));
    su_req.op    = (mul_q == iqe_pkg::MP_DIV) ? iqe_pkg::SU_DIV : iqe_pkg::SU_MUL;
  end

  // accumulators and status
  always_comb begin
    sum_d        = sum_q;
    term_d       = term_q;
    sign_d       = sign_q;
    mul_d        = mul_q;
    num_d        = num_q;
    have_d       = have_q;
    err_d        = err_q;
    op_d         = op_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    case (state_q)
      iqe_pkg::S_IDLE: begin
        if (in_acc && !hard_err) begin
          if (is_digit) begin
            num_d  = num_ovf ? iqe_pkg::NUM_MAX : num_ext[NW-1:0];
            have_d = 1'b1;
            if (num_ovf && (err_q == iqe_pkg::ST_OK)) err_d = iqe_pkg::ST_OVERFLOW;
            if (in_i.last) op_d = iqe_pkg::OP_END;
          end else if (is_space) begin
            if (in_i.last) begin
              if (have_q) op_d = iqe_pkg::OP_END;
              else        err_d = iqe_pkg::ST_SYNTAX;
            end
          end else if (is_op) begin
            if (!have_q) begin
              err_d = iqe_pkg::ST_SYNTAX;
            end else if (in_i.last) begin
              // the operator closes the number, then nothing follows it
              err_d = ((mul_q == iqe_pkg::MP_DIV) && (num_q == '0)) ?
                      iqe_pkg::ST_DIVZERO : iqe_pkg::ST_SYNTAX;
            end else begin
              op_d = char_op;
            end
          end else begin
            err_d = iqe_pkg::ST_SYNTAX;
          end
        end
      end
      iqe_pkg::S_CLOSE: begin
        if (mul_q == iqe_pkg::MP_DIV) begin
          if (num_q == '0) err_d = iqe_pkg::ST_DIVZERO;
        end else if (mul_q != iqe_pkg::MP_MUL) begin
          term_d = num_val;
          num_d  = '0;
          have_d = 1'b0;
        end
      end
      iqe_pkg::S_CALC: begin
        if (su_rsp.done) begin
          term_d = su_res;
          num_d  = '0;
          have_d = 1'b0;
          if (su_rsp.ovf && (err_q == iqe_pkg::ST_OK)) err_d = iqe_pkg::ST_OVERFLOW;
        end
      end
      iqe_pkg::S_OPER: begin
        if (op_q == iqe_pkg::OP_MUL) begin
          mul_d = iqe_pkg::MP_MUL;
        end else if (op_q == iqe_pkg::OP_DIV) begin
          mul_d = iqe_pkg::MP_DIV;
        end else begin
          // fold the term into the sum with saturation
          if (tot > POS_LIM) begin
            sum_d = POS_LIM[VW-1:0];
            if (err_q == iqe_pkg::ST_OK) err_d = iqe_pkg::ST_OVERFLOW;
          end else if (tot < NEG_LIM) begin
            sum_d = NEG_LIM[VW-1:0];
            if (err_q == iqe_pkg::ST_OK) err_d = iqe_pkg::ST_OVERFLOW;
          end else begin
            sum_d = tot[VW-1:0];
          end
          term_d = '0;
          mul_d  = iqe_pkg::MP_NONE;
          sign_d = (op_q == iqe_pkg::OP_MINUS);
        end
      end
      iqe_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = hard_err ? '0 : sum_q;
          out_status_d = err_q;
          sum_d        = '0;
          term_d       = '0;
          sign_d       = 1'b0;
          mul_d        = iqe_pkg::MP_NONE;
          num_d        = '0;
          have_d       = 1'b0;
          err_d        = iqe_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iqe_pkg::S_IDLE;
      sum_q       <= '0;
      term_q      <= '0;
      sign_q      <= 1'b0;
      mul_q       <= iqe_pkg::MP_NONE;
      num_q       <= '0;
      have_q      <= 1'b0;
      err_q       <= iqe_pkg::ST_OK;
      op_q        <= iqe_pkg::OP_PLUS;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      term_q      <= term_d;
      sign_q      <= sign_d;
      mul_q       <= mul_d;
      num_q       <= num_d;
      have_q      <= have_d;
      err_q       <= err_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output item payload
  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign res_o.valid  = out_valid_q;
  assign res_o.value  = out_value_q;
  assign res_o.status = out_status_q;

endmodule

// ===== src/iqe_serial_unit.sv =====
// iqe_serial_unit: bit-serial fixed-point multiply (shift-add) and divide (restoring)
// one result bit per cycle, then a saturation step; depends on iqe_pkg

module iqe_serial_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  iqe_pkg::su_req_t                  req_i,
  input  logic signed [iqe_pkg::VAL_W-1:0]  a_i,
  input  logic signed [iqe_pkg::VAL_W-1:0]  b_i,
  output iqe_pkg::su_rsp_t                  rsp_o,
  output logic signed [iqe_pkg::VAL_W-1:0]  res_o
);

  localparam int MW    = iqe_pkg::VAL_W;
  localparam int NW    = MW + iqe_pkg::FRAC_BITS;
  localparam int PW    = 2 * MW;
  localparam int SW    = iqe_pkg::SAT_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic                    busy_q, busy_d;
  logic                    fix_q, fix_d;
  logic                    done_q, done_d;
  logic                    ovf_q, ovf_d;
  iqe_pkg::su_op_e         op_q, op_d;
  logic                    neg_q, neg_d;
  logic [MW-1:0]           opnd_q, opnd_d;
  logic [PW-1:0]           prod_q, prod_d;
  logic [MW-1:0]           rem_q, rem_d;
  logic [NW-1:0]           sh_q, sh_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [MW-1:0]    res_q, res_d;

  logic [MW:0]             mul_sum;
  logic [MW:0]             div_try;
  logic                    div_bit;
  logic [MW:0]             div_rem;
  logic [PW-1:0]           mag_full;
  logic                    hi_nz;
  logic [SW-1:0]           lo;

  // one step of each algorithm
  always_comb begin
    mul_sum = {1'b0, prod_q[PW-1:MW]} + (prod_q[0] ? {1'b0, opnd_q} : '0);
    div_try = {rem_q, sh_q[NW-1]};
    div_bit = (div_try >= {1'b0, opnd_q});
    div_rem = div_bit ? (div_try - {1'b0, opnd_q}) : div_try;
  end

  // saturation of the final magnitude
  always_comb begin
    mag_full = (op_q == iqe_pkg::SU_MUL) ? (prod_q >> iqe_pkg::FRAC_BITS) : PW'(sh_q);
    hi_nz    = |mag_full[PW-1:SW];
    lo       = mag_full[SW-1:0];
  end

  // sequencing and datapath
  always_comb begin
    busy_d = busy_q;
    fix_d  = 1'b0;
    done_d = 1'b0;
    ovf_d  = ovf_q;
    op_d   = op_q;
    neg_d  = neg_q;
    opnd_d = opnd_q;
    prod_d = prod_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    res_d  = res_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      neg_d  = a_i[MW-1] ^ b_i[MW-1];
      rem_d  = '0;
      if (req_i.op == iqe_pkg::SU_MUL) begin
        opnd_d = iqe_pkg::mag_of(a_i);
        prod_d = {{MW{1'b0}}, iqe_pkg::mag_of(b_i)};
        cnt_d  = CNT_W'(MW);
      end else begin
        opnd_d = iqe_pkg::mag_of(b_i);
        sh_d   = NW'(iqe_pkg::mag_of(a_i)) << iqe_pkg::FRAC_BITS;
        cnt_d  = CNT_W'(NW);
      end
    end else if (busy_q) begin
      if (op_q == iqe_pkg::SU_MUL) begin
        prod_d = {mul_sum, prod_q[MW-1:1]};
      end else begin
        rem_d = div_rem[MW-1:0];
        sh_d  = {sh_q[NW-2:0], div_bit};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        fix_d  = 1'b1;
      end
    end else if (fix_q) begin
      done_d = 1'b1;
      if (neg_q) begin
        ovf_d = hi_nz || (lo > iqe_pkg::SAT_MIN_MAG);
        res_d = ovf_d ? (MW'(0) - MW'(iqe_pkg::SAT_MIN_MAG)) : (MW'(0) - MW'(lo));
      end else begin
        ovf_d = hi_nz || (lo > iqe_pkg::SAT_MAX);
        res_d = ovf_d ? MW'(iqe_pkg::SAT_MAX) : MW'(lo);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= iqe_pkg::SU_MUL;
    end else begin
      busy_q <= busy_d;
      fix_q  <= fix_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  // data registers
  always_ff @(posedge clk_i) begin
    ovf_q  <= ovf_d;
    neg_q  <= neg_d;
    opnd_q <= opnd_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    res_q  <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign res_o      = res_q;

endmodule

// ===== src/iqe_checker.sv =====
// iqe_checker: port-level assertions for the infix expression evaluator, and its bind
// depends on iqe_pkg and infix_expression_evaluator_unit

module iqe_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             in_last_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic signed [iqe_pkg::VAL_W-1:0] out_value_i,
  input logic [iqe_pkg::STAT_W-1:0]       out_status_i
);

  logic [1:0] pend_q, pend_d;
  logic       last_acc;
  logic       out_acc;

  assign last_acc = in_valid_i && in_ready_i && in_last_i;
  assign out_acc  = out_valid_i && out_ready_i;

  // expressions ended but not yet delivered
  always_comb begin
    pend_d = pend_q + {1'b0, last_acc} - {1'b0, out_acc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) && $stable(out_status_i))
    else $error("result item changed while stalled");

  // errors give a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((out_status_i == iqe_pkg::ST_SYNTAX) || (out_status_i == iqe_pkg::ST_DIVZERO))
    |-> out_value_i == '0)
    else $error("error status with nonzero value");

  // no result without a finished expression
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != 2'd0)
    else $error("result item with no final character");

  // at most one expression waits behind the output register
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many expressions outstanding");

endmodule

bind infix_expression_evaluator_unit iqe_checker u_iqe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_last_i    (in_i.last),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .out_value_i  (res_o.value),
  .out_status_i (res_o.status)
);
